// ===== sv/pcgs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the per-channel gain and saturate unit.
// No dependencies; every other file refers to it by scoped names.
package pcgs_pkg;

  // Sample format codes
  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_S24 = 2'd1;
  localparam logic [1:0] FMT_S32 = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHAN_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PASSTHROUGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN0       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN1       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN2       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN3       = 3'd6;

  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned NUM_GAINS  = 4;

  localparam logic [1:0]        FORMAT_RESET     = FMT_S32;
  localparam logic [2:0]        CHAN_COUNT_RESET = 3'd2;
  localparam logic [GAIN_W-1:0] GAIN_RESET       = 31'd65536;

  // Saturation bounds, in the width of the shifted product
  localparam logic signed [63:0] S16_MAX = 64'sd32767;
  localparam logic signed [63:0] S16_MIN = -64'sd32768;
  localparam logic signed [63:0] S24_MAX = 64'sd8388607;
  localparam logic signed [63:0] S24_MIN = -64'sd8388608;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] sample_in;
    logic               end_of_block;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic [1:0]         channel_out;
  } result_t;

  // Classified sample handed from the front to the back
  typedef struct packed {
    logic               bypass;
    logic [1:0]         fmt;
    logic [1:0]         channel;
    logic [GAIN_W-1:0]  gain;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== sv/pcgs_fifo.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of raw words, used between stages.
// Depends on pcgs_pkg for the status struct.
module pcgs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       rd,
  output logic [WIDTH-1:0]           rdata,
  output pcgs_pkg::q_status_t        status,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == FULL_COUNT);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rdata = mem[rd_ptr];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + CW'(1))
    else $error("queue count did not rise on a lone write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - CW'(1))
    else $error("queue count did not fall on a lone read");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule

// ===== sv/pcgs_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, channel counter and sample classification.
// Depends on pcgs_pkg; feeds the middle queue.
module pcgs_front #(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [pcgs_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [pcgs_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   push,
  input  pcgs_pkg::item_t                        item,
  input  pcgs_pkg::q_status_t                    mid_status,
  output logic                                   entry_wr,
  output pcgs_pkg::entry_t                       entry
);

  logic [1:0]                  sample_format;
  logic [2:0]                  channel_count;
  logic                        passthrough;
  logic [pcgs_pkg::GAIN_W-1:0] gain [pcgs_pkg::NUM_GAINS];
  logic [1:0]                  channel_index;
  logic [1:0]                  channel_index_next;
  logic [2:0]                  nch;
  logic [2:0]                  ch_inc;
  logic signed [31:0]          sext16;
  logic signed [31:0]          sext24;
  logic signed [31:0]          gain_value;

  assign entry_wr = push && !mid_status.full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= pcgs_pkg::FORMAT_RESET;
      channel_count <= pcgs_pkg::CHAN_COUNT_RESET;
      passthrough   <= 1'b0;
      for (int i = 0; i < pcgs_pkg::NUM_GAINS; i++) begin
        gain[i] <= pcgs_pkg::GAIN_RESET;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        pcgs_pkg::REG_FORMAT:      sample_format <= cfg_data[1:0];
        pcgs_pkg::REG_CHAN_COUNT:  channel_count <= cfg_data[2:0];
        pcgs_pkg::REG_PASSTHROUGH: passthrough   <= cfg_data[0];
        pcgs_pkg::REG_GAIN0:       gain[0]       <= cfg_data;
        pcgs_pkg::REG_GAIN1:       gain[1]       <= cfg_data;
        pcgs_pkg::REG_GAIN2:       gain[2]       <= cfg_data;
        pcgs_pkg::REG_GAIN3:       gain[3]       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the channel count and pick the next channel
  always_comb begin
    if (channel_count == 3'd0) begin
      nch = 3'd1;
    end else if (channel_count > 3'(MAX_CHANNELS)) begin
      nch = 3'(MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end
    ch_inc = {1'b0, channel_index} + 3'd1;
    if (item.end_of_block || ch_inc >= nch) begin
      channel_index_next = 2'd0;
    end else begin
      channel_index_next = ch_inc[1:0];
    end
  end

  // Advance the channel counter on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= 2'd0;
    end else if (entry_wr) begin
      channel_index <= channel_index_next;
    end
  end

  // Classify the sample: sign-extend per format (passthrough extends only s16), flag passthrough
  assign sext16 = {{16{item.sample_in[15]}}, item.sample_in[15:0]};
  assign sext24 = {{8{item.sample_in[23]}}, item.sample_in[23:0]};

  always_comb begin
    case (sample_format)
      pcgs_pkg::FMT_S16: gain_value = sext16;
      pcgs_pkg::FMT_S24: gain_value = sext24;
      default:           gain_value = item.sample_in;
    endcase
    entry.bypass  = passthrough;
    entry.fmt     = sample_format;
    entry.channel = channel_index;
    entry.gain    = gain[channel_index];
    if (passthrough) begin
      entry.value = (sample_format == pcgs_pkg::FMT_S16) ? sext16 : item.sample_in;
    end else begin
      entry.value = gain_value;
    end
  end

  a_eob_restart: assert property (@(posedge clk) disable iff (rst)
    (entry_wr && item.end_of_block) |=> channel_index == 2'd0)
    else $error("channel counter did not restart after end of block");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    (push && mid_status.full) |=> $stable(channel_index))
    else $error("channel counter moved without a transfer");

endmodule

// ===== sv/pcgs_back.sv =====
`timescale 1ns / 1ps
// Back end: multiply by the gain, round, shift and saturate to the format.
// Depends on pcgs_pkg; drains the middle queue into the output queue.
module pcgs_back #(
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned OUT_DEPTH      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pcgs_pkg::entry_t               entry,
  input  pcgs_pkg::q_status_t            mid_status,
  output logic                           entry_rd,
  input  pcgs_pkg::q_status_t            out_status,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_wr,
  output pcgs_pkg::result_t              res
);

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);
  localparam logic [CW:0] OUT_LIMIT = (CW + 1)'(OUT_DEPTH);
  localparam logic signed [63:0] ROUND = 64'sd1 <<< (GAIN_FRAC_BITS - 1);

  logic               s1_valid;
  logic               s1_bypass;
  logic [1:0]         s1_fmt;
  logic [1:0]         s1_channel;
  logic signed [31:0] s1_value;
  logic signed [63:0] s1_prod;
  logic [CW:0]        in_flight;
  logic signed [63:0] rounded;
  logic signed [63:0] shifted;
  logic signed [63:0] lo;
  logic signed [63:0] hi;
  logic signed [63:0] clamped;

  // Issue only with room reserved in the output queue
  assign in_flight = {1'b0, out_count} + (CW + 1)'(s1_valid);
  assign entry_rd  = !mid_status.empty && (in_flight < OUT_LIMIT);

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= entry_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_rd) begin
      s1_bypass  <= entry.bypass;
      s1_fmt     <= entry.fmt;
      s1_channel <= entry.channel;
      s1_value   <= entry.value;
      s1_prod    <= $signed(entry.value) * $signed({1'b0, entry.gain});
    end
  end

  // Round half up, floor shift and saturate
  always_comb begin
    rounded = s1_prod + ROUND;
    shifted = rounded >>> GAIN_FRAC_BITS;
    case (s1_fmt)
      pcgs_pkg::FMT_S16: begin
        lo = pcgs_pkg::S16_MIN;
        hi = pcgs_pkg::S16_MAX;
      end
      pcgs_pkg::FMT_S24: begin
        lo = pcgs_pkg::S24_MIN;
        hi = pcgs_pkg::S24_MAX;
      end
      default: begin
        lo = pcgs_pkg::S32_MIN;
        hi = pcgs_pkg::S32_MAX;
      end
    endcase
    if (shifted < lo) begin
      clamped = lo;
    end else if (shifted > hi) begin
      clamped = hi;
    end else begin
      clamped = shifted;
    end
  end

  assign res_wr          = s1_valid;
  assign res.sample_out  = s1_bypass ? s1_value : clamped[31:0];
  assign res.channel_out = s1_channel;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !out_status.full)
    else $error("result written into a full output queue");

  a_issue_reserve: assert property (@(posedge clk) disable iff (rst)
    entry_rd |=> s1_valid)
    else $error("issued sample missing from multiply stage");

endmodule

// ===== sv/per_channel_gain_saturate_unit.sv =====
`timescale 1ns / 1ps
// Per-channel gain with saturation: top level tying front, queues and back.
// Depends on pcgs_pkg, pcgs_fifo, pcgs_front and pcgs_back.
//
// Interleaved audio samples enter through push/full one per cycle; each takes
// the gain of the channel named by a running counter that wraps after the
// configured channel count and restarts after end_of_block. The signed product
// is rounded half up, shifted by GAIN_FRAC_BITS and saturated to s16, s24 or
// s32; passthrough copies the sample instead. The sustained rate is one sample
// per clock, set by the single 32x32 multiply stage; after its transfer a sample
// passes through the middle queue and the multiply register into the output
// queue, from which it can be popped. The output queue needs OUT_DEPTH of at
// least 3 to hold that rate while pop is high every cycle. Write configuration
// only while the unit holds no samples.
module per_channel_gain_saturate_unit #(
  parameter int unsigned MAX_CHANNELS   = 4,
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned MID_DEPTH      = 2,
  parameter int unsigned OUT_DEPTH      = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pcgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  pcgs_pkg::item_t                  item,
  output logic                             empty,
  input  logic                             pop,
  output pcgs_pkg::result_t                result
);

  localparam int unsigned ENTRY_W  = $bits(pcgs_pkg::entry_t);
  localparam int unsigned RESULT_W = $bits(pcgs_pkg::result_t);

  pcgs_pkg::q_status_t               mid_status;
  pcgs_pkg::q_status_t               out_status;
  logic [$clog2(MID_DEPTH+1)-1:0]    mid_count;
  logic [$clog2(OUT_DEPTH+1)-1:0]    out_count;
  logic                              entry_wr;
  logic                              entry_rd;
  pcgs_pkg::entry_t                  entry_in;
  pcgs_pkg::entry_t                  entry_out;
  logic [ENTRY_W-1:0]                entry_bits;
  logic                              res_wr;
  pcgs_pkg::result_t                 res;
  logic [RESULT_W-1:0]               result_bits;

  assign full      = mid_status.full;
  assign empty     = out_status.empty;
  assign entry_out = pcgs_pkg::entry_t'(entry_bits);
  assign result    = pcgs_pkg::result_t'(result_bits);

  // Accept and classify
  pcgs_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .item       (item),
    .mid_status (mid_status),
    .entry_wr   (entry_wr),
    .entry      (entry_in)
  );

  // Decouple front and back
  pcgs_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (entry_wr),
    .wdata  (entry_in),
    .rd     (entry_rd),
    .rdata  (entry_bits),
    .status (mid_status),
    .count  (mid_count)
  );

  // Multiply, round and saturate
  pcgs_back #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .OUT_DEPTH     (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .entry      (entry_out),
    .mid_status (mid_status),
    .entry_rd   (entry_rd),
    .out_status (out_status),
    .out_count  (out_count),
    .res_wr     (res_wr),
    .res        (res)
  );

  // Hold results until popped
  pcgs_fifo #(
    .WIDTH(RESULT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_wr),
    .wdata  (res),
    .rd     (pop),
    .rdata  (result_bits),
    .status (out_status),
    .count  (out_count)
  );

  a_mid_count: assert property (@(posedge clk) disable iff (rst)
    mid_status.empty |-> mid_count == '0)
    else $error("middle queue empty flag disagrees with its count");

endmodule
